// ===== rtl/core/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, constants and sequencer states of the music section classifier.
// ----------------------------------------------------------------------------
package msc_pkg;

  // frame layout and history
  localparam int Bins             = 12;
  localparam int HistoryDepthDef  = 64;

  // envelope smoothing, alpha 0.05 in q0.16
  localparam int AlphaQ16         = 3277;
  localparam int AlphaInvQ16      = 65536 - AlphaQ16;
  localparam int RoundHalf        = 32768;

  // decision thresholds
  localparam int LowMargin        = 655;
  localparam int RepeatThr        = 19660;
  localparam int NoveltyThr       = 16384;
  localparam int ScoreOne         = 32768;
  localparam int DefaultFpt       = 30;
  localparam int MinHistory       = 8;
  localparam int IntroHistory     = 12;
  localparam int ChorusHistory    = 20;
  localparam int SwitchTicks      = 3;

  // correlation lags
  localparam int NovLagFirst      = 2;
  localparam int NovLagLast       = 6;
  localparam int RepLagFirst      = 8;
  localparam int RepLagLast       = 30;

  // datapath widths
  localparam int WideW            = 40;
  localparam int RootW            = 20;
  localparam int QuotW            = 16;

  // register index of frames_per_tick
  localparam logic RegFpt         = 1'b0;

  typedef enum logic [2:0] {
    SecUnknown = 3'd0,
    SecIntro   = 3'd1,
    SecVerse   = 3'd2,
    SecChorus  = 3'd3,
    SecBridge  = 3'd4,
    SecOutro   = 3'd5
  } section_t;

  typedef enum logic {
    IterSqrt = 1'b0,
    IterDiv  = 1'b1
  } iter_op_t;

  // request to the shared root / divide unit
  typedef struct packed {
    logic              start;
    iter_op_t          op;
    logic [WideW-1:0]  a;
    logic [WideW-1:0]  b;
  } iter_req_t;

  // status of the shared root / divide unit
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RootW-1:0]  result;
  } iter_rsp_t;

  typedef enum logic [4:0] {
    StIdle,
    StEnv1,
    StEnv2,
    StEnv3,
    StCopy,
    StCheck,
    StLag,
    StBin0,
    StBin1,
    StBin2,
    StBin3,
    StCorr0,
    StCorr1,
    StCorr2,
    StCorr3,
    StSqrtA,
    StSqrtB,
    StDen,
    StDiv,
    StLagEnd,
    StScore,
    StPickRd,
    StPickLd,
    StScanRd,
    StScanCmp,
    StPickEnd,
    StClass,
    StOut
  } state_t;

endpackage

// ===== rtl/core/msc_in_if.sv =====
// ----------------------------------------------------------------------------
// msc_in_if
// Input channel: chroma bins and frame-end beats with valid/ready.
// ----------------------------------------------------------------------------
interface msc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] chroma_value;
  logic [15:0] frame_rms;

  modport source (output valid, kind, chroma_value, frame_rms, input ready);
  modport sink   (input valid, kind, chroma_value, frame_rms, output ready);
endinterface

// ===== rtl/core/msc_out_if.sv =====
// ----------------------------------------------------------------------------
// msc_out_if
// Result channel: one beat per frame end with valid/ready.
// ----------------------------------------------------------------------------
interface msc_out_if;
  logic        valid;
  logic        ready;
  logic        ticked;
  logic [2:0]  section;
  logic [15:0] novelty;
  logic [15:0] repeat_score;
  logic [15:0] energy_level;

  modport source (output valid, ticked, section, novelty, repeat_score, energy_level,
                  input ready);
  modport sink   (input valid, ticked, section, novelty, repeat_score, energy_level,
                  output ready);
endinterface

// ===== rtl/core/msc_ram.sv =====
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msc_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/msc_iter.sv =====
// ----------------------------------------------------------------------------
// msc_iter
// Shared bit-serial unit: floor square root of a 40-bit value (2 bits a cycle)
// or 16-bit quotient of a correlation numerator by its denominator.
// ----------------------------------------------------------------------------
module msc_iter
  import msc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  localparam int SqrtSteps = WideW / 2;
  localparam int DivSteps  = QuotW;

  logic             busy;
  logic             done;
  iter_op_t         op;
  logic [4:0]       cnt;
  logic [WideW:0]   acc;     // radicand remainder or division remainder
  logic [WideW:0]   root;    // partial root
  logic [WideW-1:0] bitv;    // root bit weight
  logic [WideW-1:0] den;
  logic [QuotW-1:0] quo;

  logic [WideW:0]   trial;
  logic [WideW:0]   shifted;
  logic             last;

  // step arithmetic
  always_comb begin
    trial   = root + {1'b0, bitv};
    shifted = (cnt == '0) ? acc : {acc[WideW-1:0], 1'b0};
    last    = (op == IterSqrt) ? (cnt == 5'(SqrtSteps - 1)) : (cnt == 5'(DivSteps - 1));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op   <= req.op;
      cnt  <= '0;
      acc  <= {1'b0, req.a};
      den  <= req.b;
      root <= '0;
      bitv <= {2'b01, {(WideW-2){1'b0}}};
      quo  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (op == IterSqrt) begin
        if (acc >= trial) begin
          acc  <= acc - trial;
          root <= (root >> 1) + {1'b0, bitv};
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end else begin
        if (shifted >= {1'b0, den}) begin
          acc <= shifted - {1'b0, den};
          quo <= {quo[QuotW-2:0], 1'b1};
        end else begin
          acc <= shifted;
          quo <= {quo[QuotW-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = (op == IterSqrt) ? root[RootW-1:0] : {{(RootW-QuotW){1'b0}}, quo};

endmodule

// ===== rtl/core/music_section_classifier.sv =====
// ----------------------------------------------------------------------------
// music_section_classifier
// Frame-rate music section tracker built around one shared multiplier and
// one bit-serial root / divide unit under a small sequencer.
// ----------------------------------------------------------------------------
// Chroma beats are accepted back to back while the sequencer is idle. A
// frame-end beat updates the envelope through the shared multiplier; when a
// tick falls due it also copies the 12 staged bins into the chroma history
// and, once that holds MinHistory entries or more, scores up to 28 lags, each
// by multiply-accumulate over the bins and then the root / divide unit, and
// ranks the envelope history through its single read port. Input is not ready
// while a frame end is being processed. The history RAMs need no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module music_section_classifier
  import msc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  msc_in_if.sink      item_in,
  msc_out_if.source   result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int HW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int CDepth = HISTORY_DEPTH * Bins;
  localparam int CAW    = $clog2(CDepth);
  localparam int BW     = $clog2(Bins);
  localparam logic [HW:0] DepthM1 = (HW+1)'(HISTORY_DEPTH - 1);
  localparam logic [HW:0] DepthW  = (HW+1)'(HISTORY_DEPTH);

  // architectural state
  state_t            state, state_next;
  logic [7:0]        fpt;
  logic [15:0]       env;
  logic [7:0]        frame_cnt;
  logic [BW-1:0]     bin_cnt;
  logic [15:0]       staged [Bins];
  logic [CW-1:0]     hist_count;
  logic [HW-1:0]     head;
  logic [15:0]       novelty_r;
  logic [15:0]       repeat_r;
  section_t          section_r;
  logic [1:0]        dissent;

  // working registers
  logic [15:0]       rms_r;
  logic              ticked_r;
  logic [31:0]       env_acc;
  logic [BW-1:0]     bin;
  logic [4:0]        lag;
  logic [19:0]       sa, sb;
  logic [35:0]       saa, sab, sbb;
  logic [15:0]       y;
  logic [WideW-1:0]  num, da, db;
  logic [RootW-1:0]  ra;
  logic [15:0]       score;
  logic [15:0]       best_rec, best_rep;
  logic [CW-1:0]     pick, scan, lt_cnt, eq_cnt, k20, kmed;
  logic [15:0]       pick_val, p20, med;
  logic [39:0]       mul_p;

  // output register
  logic              out_valid;
  logic              out_ticked;
  logic [2:0]        out_section;
  logic [15:0]       out_novelty, out_repeat, out_energy;

  // combinational controls
  logic [19:0]       mul_a, mul_b;
  logic              c_we;
  logic [CAW-1:0]    c_waddr, c_raddr;
  logic [15:0]       c_rdata;
  logic              e_we;
  logic [HW-1:0]     e_raddr;
  logic [15:0]       e_rdata;
  iter_req_t         iter_req;
  iter_rsp_t         iter_rsp;

  logic              in_fire;
  logic [15:0]       x;
  logic [HW:0]       slot_sum;
  logic [HW-1:0]     slot_b;
  logic [HW:0]       head_sum;
  logic [WideW-1:0]  sab12, saa12, sbb12;
  logic [7:0]        fpt_eff;
  logic [8:0]        fc_inc;
  logic              tick_due;
  logic [32:0]       env_sum;
  logic              last_lag;
  logic [4:0]        lag_next;
  logic [15:0]       score_q;
  logic              is_high, is_low, is_wind;
  section_t          cand;

  function automatic logic [WideW-1:0] times12(input logic [35:0] v);
    logic [WideW-1:0] w;
    w = {4'b0, v};
    return (w << 3) + (w << 2);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFpt) ? {24'b0, fpt} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fpt <= 8'(DefaultFpt);
    end else if (psel && penable && pwrite && paddr[2] == RegFpt) begin
      fpt <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // shared units and memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  msc_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (iter_req),
    .rsp (iter_rsp)
  );

  msc_ram #(.Width(16), .Depth(CDepth)) u_chroma_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (x),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  msc_ram #(.Width(16), .Depth(HISTORY_DEPTH)) u_energy_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (head),
    .wdata (env),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // ---------------------------------------------------------------------------
  // shared combinational terms
  // ---------------------------------------------------------------------------
  always_comb begin
    in_fire  = item_in.valid && item_in.ready;
    x        = staged[bin];
    slot_sum = {1'b0, head} + DepthM1 - (HW+1)'(lag);
    slot_b   = (slot_sum >= DepthW) ? HW'(slot_sum - DepthW) : slot_sum[HW-1:0];
    head_sum = {1'b0, head} + (HW+1)'(1);
    sab12    = times12(sab);
    saa12    = times12(saa);
    sbb12    = times12(sbb);
    fpt_eff  = (fpt == 8'd0) ? 8'(DefaultFpt) : fpt;
    fc_inc   = {1'b0, frame_cnt} + 9'd1;
    tick_due = fc_inc >= {1'b0, fpt_eff};
    env_sum  = {1'b0, env_acc} + {1'b0, mul_p[31:0]} + 33'(RoundHalf);
    score_q  = (iter_rsp.result[QuotW-1:0] > 16'(ScoreOne))
               ? 16'(ScoreOne) : iter_rsp.result[QuotW-1:0];
  end

  // next lag to score
  always_comb begin
    lag_next = lag + 5'd1;
    last_lag = 1'b0;
    if (lag == 5'(NovLagLast)) begin
      lag_next = 5'(RepLagFirst);
      last_lag = !(hist_count > CW'(RepLagFirst));
    end else if (lag >= 5'(RepLagFirst)) begin
      last_lag = (lag == 5'(RepLagLast)) || !(CW'(lag_next) < hist_count);
    end
  end

  // energy tests and section candidate
  always_comb begin
    is_high = (19'(env) * 19'd5) > (19'(med) * 19'd6);
    is_low  = (17'(env) + 17'(LowMargin)) < 17'(p20);
    is_wind = {1'b0, env, 1'b0} < 18'(med);
    if (hist_count < CW'(IntroHistory)) begin
      cand = SecIntro;
    end else if (hist_count >= CW'(ChorusHistory) && repeat_r > 16'(RepeatThr) && is_high) begin
      cand = SecChorus;
    end else if (repeat_r > 16'(RepeatThr)) begin
      cand = SecVerse;
    end else if (novelty_r > 16'(NoveltyThr) && !is_low) begin
      cand = SecBridge;
    end else if (is_low || is_wind) begin
      cand = SecOutro;
    end else begin
      cand = SecVerse;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  assign item_in.ready = (state == StIdle);

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    c_we       = 1'b0;
    c_waddr    = CAW'(head) * CAW'(Bins) + CAW'(bin);
    c_raddr    = CAW'(slot_b) * CAW'(Bins) + CAW'(bin);
    e_we       = 1'b0;
    e_raddr    = pick[HW-1:0];
    iter_req   = '0;
    case (state)
      StIdle: begin
        if (in_fire && item_in.kind) begin
          state_next = StEnv1;
        end
      end
      StEnv1: begin
        mul_a      = 20'(env);
        mul_b      = 20'(AlphaInvQ16);
        state_next = StEnv2;
      end
      StEnv2: begin
        mul_a      = 20'(rms_r);
        mul_b      = 20'(AlphaQ16);
        state_next = StEnv3;
      end
      StEnv3: begin
        state_next = tick_due ? StCopy : StOut;
      end
      StCopy: begin
        c_we = 1'b1;
        e_we = (bin == '0);
        if (bin == BW'(Bins - 1)) begin
          state_next = StCheck;
        end
      end
      StCheck: begin
        state_next = (hist_count < CW'(MinHistory)) ? StOut : StLag;
      end
      StLag: begin
        state_next = StBin0;
      end
      StBin0: begin
        mul_a      = 20'(x);
        mul_b      = 20'(x);
        state_next = StBin1;
      end
      StBin1: begin
        mul_a      = 20'(x);
        mul_b      = 20'(c_rdata);
        state_next = StBin2;
      end
      StBin2: begin
        mul_a      = 20'(y);
        mul_b      = 20'(y);
        state_next = StBin3;
      end
      StBin3: begin
        state_next = (bin == BW'(Bins - 1)) ? StCorr0 : StBin0;
      end
      StCorr0: begin
        mul_a      = sa;
        mul_b      = sb;
        state_next = StCorr1;
      end
      StCorr1: begin
        mul_a      = sa;
        mul_b      = sa;
        state_next = (sab12 <= mul_p) ? StLagEnd : StCorr2;
      end
      StCorr2: begin
        mul_a      = sb;
        mul_b      = sb;
        state_next = StCorr3;
      end
      StCorr3: begin
        state_next = StSqrtA;
      end
      StSqrtA: begin
        if (iter_rsp.done) begin
          iter_req.start = 1'b1;
          iter_req.op    = IterSqrt;
          iter_req.a     = db;
          state_next     = StSqrtB;
        end else if (!iter_rsp.busy) begin
          iter_req.start = 1'b1;
          iter_req.op    = IterSqrt;
          iter_req.a     = da;
        end
      end
      StSqrtB: begin
        mul_a = ra;
        mul_b = iter_rsp.result;
        if (iter_rsp.done) begin
          state_next = StDen;
        end
      end
      StDen: begin
        if (mul_p == '0 || num >= {mul_p[WideW-2:0], 1'b0} || mul_p[WideW-1]) begin
          state_next = StLagEnd;
        end else begin
          iter_req.start = 1'b1;
          iter_req.op    = IterDiv;
          iter_req.a     = num;
          iter_req.b     = mul_p;
          state_next     = StDiv;
        end
      end
      StDiv: begin
        if (iter_rsp.done) begin
          state_next = StLagEnd;
        end
      end
      StLagEnd: begin
        state_next = last_lag ? StScore : StLag;
      end
      StScore: begin
        state_next = StPickRd;
      end
      StPickRd: begin
        state_next = StPickLd;
      end
      StPickLd: begin
        state_next = StScanRd;
      end
      StScanRd: begin
        e_raddr    = scan[HW-1:0];
        state_next = StScanCmp;
      end
      StScanCmp: begin
        state_next = (scan + CW'(1) == hist_count) ? StPickEnd : StScanRd;
      end
      StPickEnd: begin
        state_next = (pick + CW'(1) == hist_count) ? StClass : StPickRd;
      end
      StClass: begin
        state_next = StOut;
      end
      StOut: begin
        if (!out_valid || result_out.ready) begin
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      env        <= '0;
      frame_cnt  <= '0;
      bin_cnt    <= '0;
      hist_count <= '0;
      head       <= '0;
      novelty_r  <= '0;
      repeat_r   <= '0;
      section_r  <= SecUnknown;
      dissent    <= '0;
      ticked_r   <= 1'b0;
    end else begin
      case (state)
        StIdle: begin
          if (in_fire) begin
            if (item_in.kind) begin
              bin_cnt <= '0;
            end else if (bin_cnt < BW'(Bins)) begin
              bin_cnt <= bin_cnt + BW'(1);
            end
          end
        end
        StEnv3: begin
          env      <= env_sum[31:16];
          ticked_r <= tick_due;
          if (tick_due) begin
            frame_cnt <= 8'(fc_inc - {1'b0, fpt_eff});
          end else begin
            frame_cnt <= fc_inc[7:0];
          end
        end
        StCopy: begin
          if (bin == BW'(Bins - 1)) begin
            head <= (head_sum == DepthW) ? '0 : head_sum[HW-1:0];
            if (hist_count < CW'(HISTORY_DEPTH)) begin
              hist_count <= hist_count + CW'(1);
            end
          end
        end
        StCheck: begin
          if (hist_count < CW'(MinHistory)) begin
            section_r <= SecUnknown;
          end
        end
        StScore: begin
          novelty_r <= 16'(ScoreOne) - best_rec;
          repeat_r  <= best_rep;
        end
        StClass: begin
          if (cand != section_r) begin
            if (dissent + 2'd1 >= 2'(SwitchTicks)) begin
              section_r <= cand;
              dissent   <= '0;
            end else begin
              dissent <= dissent + 2'd1;
            end
          end else begin
            dissent <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // working datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        if (in_fire) begin
          if (item_in.kind) begin
            rms_r <= item_in.frame_rms;
            bin   <= '0;
          end else if (bin_cnt < BW'(Bins)) begin
            staged[bin_cnt] <= item_in.chroma_value;
          end
        end
      end
      StEnv3: begin
        bin <= '0;
      end
      StEnv2: begin
        env_acc <= mul_p[31:0];
      end
      StCopy: begin
        bin <= (bin == BW'(Bins - 1)) ? '0 : bin + BW'(1);
      end
      StCheck: begin
        lag      <= 5'(NovLagFirst);
        best_rec <= '0;
        best_rep <= '0;
      end
      StLag: begin
        bin <= '0;
        sa  <= '0;
        sb  <= '0;
        saa <= '0;
        sab <= '0;
        sbb <= '0;
      end
      StBin1: begin
        saa <= saa + 36'(mul_p[31:0]);
        sa  <= sa + 20'(x);
        y   <= c_rdata;
      end
      StBin2: begin
        sab <= sab + 36'(mul_p[31:0]);
        sb  <= sb + 20'(y);
      end
      StBin3: begin
        sbb <= sbb + 36'(mul_p[31:0]);
        bin <= (bin == BW'(Bins - 1)) ? '0 : bin + BW'(1);
      end
      StCorr1: begin
        score <= '0;
        num   <= sab12 - mul_p;
      end
      StCorr2: begin
        da <= saa12 - mul_p;
      end
      StCorr3: begin
        db <= sbb12 - mul_p;
      end
      StSqrtA: begin
        if (iter_rsp.done) begin
          ra <= iter_rsp.result;
        end
      end
      StDen: begin
        if (mul_p == '0) begin
          score <= '0;
        end else begin
          score <= 16'(ScoreOne);
        end
      end
      StDiv: begin
        if (iter_rsp.done) begin
          score <= score_q;
        end
      end
      StLagEnd: begin
        if (lag <= 5'(NovLagLast)) begin
          if (score > best_rec) begin
            best_rec <= score;
          end
        end else if (score > best_rep) begin
          best_rep <= score;
        end
        lag <= lag_next;
      end
      StScore: begin
        pick <= '0;
        kmed <= hist_count >> 1;
        k20  <= CW'((20'(hist_count) * 20'd205) >> 10);
      end
      StPickLd: begin
        pick_val <= e_rdata;
        scan     <= '0;
        lt_cnt   <= '0;
        eq_cnt   <= '0;
      end
      StScanCmp: begin
        if (e_rdata < pick_val) begin
          lt_cnt <= lt_cnt + CW'(1);
        end else if (e_rdata == pick_val) begin
          eq_cnt <= eq_cnt + CW'(1);
        end
        scan <= scan + CW'(1);
      end
      StPickEnd: begin
        if (lt_cnt <= k20 && k20 < lt_cnt + eq_cnt) begin
          p20 <= pick_val;
        end
        if (lt_cnt <= kmed && kmed < lt_cnt + eq_cnt) begin
          med <= pick_val;
        end
        pick <= pick + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == StOut && (!out_valid || result_out.ready)) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == StOut && (!out_valid || result_out.ready)) begin
      out_ticked  <= ticked_r;
      out_section <= section_r;
      out_novelty <= novelty_r;
      out_repeat  <= repeat_r;
      out_energy  <= env;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.ticked       = out_ticked;
  assign result_out.section      = out_section;
  assign result_out.novelty      = out_novelty;
  assign result_out.repeat_score = out_repeat;
  assign result_out.energy_level = out_energy;

`ifndef SYNTH
  // switch hysteresis never reaches its limit without switching
  a_dissent_bound: assert property (@(posedge clk) disable iff (rst)
    dissent < 2'(SwitchTicks))
    else $error("dissent count reached switch limit");

  // history fill never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= CW'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  // short history always reports unknown
  a_short_unknown: assert property (@(posedge clk) disable iff (rst)
    (hist_count < CW'(MinHistory)) |-> (section_r == SecUnknown))
    else $error("section known with short history");

  // the shared unit is only started when free
  a_iter_free: assert property (@(posedge clk) disable iff (rst)
    iter_req.start |-> (!iter_rsp.busy))
    else $error("root/divide unit started while busy");
`endif

endmodule
